// ===== hdl/kvt_pkg.sv =====
// Shared types and constants for the key/value table.
// Used by kvt_cell and key_value_table; depends on nothing else.
package kvt_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int VALUE_BITS_DEF = 64;
    localparam int KEY_W          = 32;
    localparam int FIELD_VALUE_W  = 64;
    localparam int ACTION_W       = 2;
    localparam int STATUS_W       = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SET   = 2'd0,
        ACT_GET   = 2'd1,
        ACT_COPY  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE
    } t_state;

    // search token flags handed from cell to cell
    typedef struct packed {
        logic tv;
        logic look_hit;
        logic dst_hit;
        logic free_hit;
    } t_tok;

    // write broadcast to all cells
    typedef struct packed {
        logic en;
        logic claim;
        logic clear;
    } t_wr;

endpackage

// ===== hdl/kvt_cell.sv =====
// One table entry plus one stage of the search chain.
// Depends on kvt_pkg (token and write structs, key width).
module kvt_cell #(
    parameter int  ENTRIES    = kvt_pkg::ENTRIES_DEF,
    parameter int  VALUE_BITS = kvt_pkg::VALUE_BITS_DEF,
    parameter int  CELL_IDX   = 0,
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [kvt_pkg::KEY_W-1:0] i_look_key,
    input  logic [kvt_pkg::KEY_W-1:0] i_dst_key,
    input  kvt_pkg::t_tok            i_tok,
    input  logic [IDX_W-1:0]         i_look_idx,
    input  logic [IDX_W-1:0]         i_dst_idx,
    input  logic [IDX_W-1:0]         i_free_idx,
    input  logic [VALUE_BITS-1:0]    i_look_value,
    output kvt_pkg::t_tok            o_tok,
    output logic [IDX_W-1:0]         o_look_idx,
    output logic [IDX_W-1:0]         o_dst_idx,
    output logic [IDX_W-1:0]         o_free_idx,
    output logic [VALUE_BITS-1:0]    o_look_value,
    input  kvt_pkg::t_wr             i_wr,
    input  logic [IDX_W-1:0]         i_wr_idx,
    input  logic [kvt_pkg::KEY_W-1:0] i_wr_key,
    input  logic [VALUE_BITS-1:0]    i_wr_value
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                      r_valid;
    logic [kvt_pkg::KEY_W-1:0] r_key;
    logic [VALUE_BITS-1:0]     r_value;

    kvt_pkg::t_tok         r_tok;
    logic [IDX_W-1:0]      r_look_idx;
    logic [IDX_W-1:0]      r_dst_idx;
    logic [IDX_W-1:0]      r_free_idx;
    logic [VALUE_BITS-1:0] r_look_value;

    logic look_match;
    logic dst_match;
    logic wr_sel;

    assign look_match = r_valid && (r_key == i_look_key);
    assign dst_match  = r_valid && (r_key == i_dst_key);
    assign wr_sel     = i_wr.en && (i_wr_idx == MY_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_tok.tv <= i_tok.tv;
            if (i_tok.tv) begin
                r_tok.look_hit <= i_tok.look_hit | look_match;
                r_tok.dst_hit  <= i_tok.dst_hit  | dst_match;
                r_tok.free_hit <= i_tok.free_hit | !r_valid;
            end
            if (wr_sel) begin
                if (i_wr.clear) begin
                    r_valid <= 1'b0;
                end else if (i_wr.claim) begin
                    r_valid <= 1'b1;
                end
            end
        end
    end

    // first hit in the chain wins, later cells pass it on untouched
    always_ff @(posedge i_clk) begin
        if (i_tok.tv) begin
            if (!i_tok.look_hit && look_match) begin
                r_look_idx   <= MY_IDX;
                r_look_value <= r_value;
            end else begin
                r_look_idx   <= i_look_idx;
                r_look_value <= i_look_value;
            end
            r_dst_idx  <= (!i_tok.dst_hit && dst_match) ? MY_IDX : i_dst_idx;
            r_free_idx <= (!i_tok.free_hit && !r_valid) ? MY_IDX : i_free_idx;
        end
        if (wr_sel && !i_wr.clear) begin
            r_value <= i_wr_value;
            if (i_wr.claim) begin
                r_key <= i_wr_key;
            end
        end
    end

    assign o_tok        = r_tok;
    assign o_look_idx   = r_look_idx;
    assign o_dst_idx    = r_dst_idx;
    assign o_free_idx   = r_free_idx;
    assign o_look_value = r_look_value;

endmodule

// ===== hdl/key_value_table.sv =====
// Key/value table top level: stream ports, command control and the cell chain.
// Depends on kvt_pkg and kvt_cell.
//
// Usage:
//   Commands arrive on the slave stream (i_s_*): tuser carries the action
//   (set, get, copy, clear), tdata carries key, source key and value.
//   Every command gives exactly one result beat on the master stream
//   (o_m_*): status and the value read by a successful get.
//   A command launches a search token into a chain of ENTRIES cells, one
//   cell per cycle, collecting the first key match, the first match of the
//   copy source and the lowest free entry. The entry update is broadcast
//   to the cells once the token leaves the chain.
//   One command is in the chain at a time; the next is taken once the last
//   has resolved, even while its result still waits on the output.
//   Reset clears every valid mark; keys and values are left as they are.
//   If the receiver stalls, the next result is held inside until the
//   output register drains, and no further command is taken meanwhile.
module key_value_table #(
    parameter int  ENTRIES    = kvt_pkg::ENTRIES_DEF,
    parameter int  VALUE_BITS = kvt_pkg::VALUE_BITS_DEF,
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,   // key[31:0], source_key[63:32], value[127:64]
    input  logic [1:0]   i_s_tuser,   // action[1:0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [71:0]  o_m_tdata    // status[1:0], read_value[65:2], zero pad[71:66]
);

    localparam int KW = kvt_pkg::KEY_W;
    localparam int FW = kvt_pkg::FIELD_VALUE_W;

    kvt_pkg::t_state  r_state;
    kvt_pkg::t_state  n_state;

    kvt_pkg::t_action r_action;
    logic [KW-1:0]         r_key;
    logic [KW-1:0]         r_look_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_start;

    logic                  r_out_valid;
    kvt_pkg::t_status      r_out_status;
    logic [FW-1:0]         r_out_read;

    kvt_pkg::t_wr          r_wr;
    logic [IDX_W-1:0]      r_wr_idx;
    logic [KW-1:0]         r_wr_key;
    logic [VALUE_BITS-1:0] r_wr_value;

    kvt_pkg::t_wr          n_wr;
    logic [IDX_W-1:0]      n_wr_idx;
    kvt_pkg::t_status      n_status;
    logic [FW-1:0]         n_read;
    logic [VALUE_BITS-1:0] store_value;

    logic s_accept;
    logic resolve;

    kvt_pkg::t_tok         tok       [ENTRIES+1];
    logic [IDX_W-1:0]      look_idx  [ENTRIES+1];
    logic [IDX_W-1:0]      dst_idx   [ENTRIES+1];
    logic [IDX_W-1:0]      free_idx  [ENTRIES+1];
    logic [VALUE_BITS-1:0] look_val  [ENTRIES+1];

    assign o_s_tready = (r_state == kvt_pkg::S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign resolve    = (r_state == kvt_pkg::S_RESOLVE) && (!r_out_valid || i_m_tready);

    // chain head
    always_comb begin
        tok[0]          = '0;
        tok[0].tv       = r_start;
        look_idx[0]     = '0;
        dst_idx[0]      = '0;
        free_idx[0]     = '0;
        look_val[0]     = '0;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        kvt_cell #(
            .ENTRIES    (ENTRIES),
            .VALUE_BITS (VALUE_BITS),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_look_key   (r_look_key),
            .i_dst_key    (r_key),
            .i_tok        (tok[g]),
            .i_look_idx   (look_idx[g]),
            .i_dst_idx    (dst_idx[g]),
            .i_free_idx   (free_idx[g]),
            .i_look_value (look_val[g]),
            .o_tok        (tok[g+1]),
            .o_look_idx   (look_idx[g+1]),
            .o_dst_idx    (dst_idx[g+1]),
            .o_free_idx   (free_idx[g+1]),
            .o_look_value (look_val[g+1]),
            .i_wr         (r_wr),
            .i_wr_idx     (r_wr_idx),
            .i_wr_key     (r_wr_key),
            .i_wr_value   (r_wr_value)
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kvt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kvt_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_state = kvt_pkg::S_SCAN;
                end
            end
            kvt_pkg::S_SCAN: begin
                if (tok[ENTRIES].tv) begin
                    n_state = kvt_pkg::S_RESOLVE;
                end
            end
            kvt_pkg::S_RESOLVE: begin
                if (resolve) begin
                    n_state = kvt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kvt_pkg::S_IDLE;
            end
        endcase
    end

    // outcome of the finished search; the last cell's payload holds still
    always_comb begin
        n_wr        = '0;
        n_wr_idx    = dst_idx[ENTRIES];
        n_status    = kvt_pkg::ST_DONE;
        n_read      = '0;
        store_value = (r_action == kvt_pkg::ACT_COPY) ? look_val[ENTRIES] : r_value;
        unique case (r_action)
            kvt_pkg::ACT_SET, kvt_pkg::ACT_COPY: begin
                if (r_action == kvt_pkg::ACT_COPY && !tok[ENTRIES].look_hit) begin
                    n_status = kvt_pkg::ST_NOT_FOUND;
                end else if (tok[ENTRIES].dst_hit) begin
                    n_wr.en  = 1'b1;
                    n_wr_idx = dst_idx[ENTRIES];
                end else if (tok[ENTRIES].free_hit) begin
                    n_wr.en    = 1'b1;
                    n_wr.claim = 1'b1;
                    n_wr_idx   = free_idx[ENTRIES];
                end else begin
                    n_status = kvt_pkg::ST_FULL;
                end
            end
            kvt_pkg::ACT_GET: begin
                if (tok[ENTRIES].look_hit) begin
                    n_read = FW'(look_val[ENTRIES]);
                end else begin
                    n_status = kvt_pkg::ST_NOT_FOUND;
                end
            end
            kvt_pkg::ACT_CLEAR: begin
                if (tok[ENTRIES].look_hit) begin
                    n_wr.en    = 1'b1;
                    n_wr.clear = 1'b1;
                    n_wr_idx   = look_idx[ENTRIES];
                end else begin
                    n_status = kvt_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                n_status = kvt_pkg::ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_wr        <= '0;
        end else begin
            r_start <= s_accept;
            r_wr    <= resolve ? n_wr : '0;
            if (resolve) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_action   <= kvt_pkg::t_action'(i_s_tuser);
            r_key      <= i_s_tdata[31:0];
            r_look_key <= (kvt_pkg::t_action'(i_s_tuser) == kvt_pkg::ACT_COPY) ?
                          i_s_tdata[63:32] : i_s_tdata[31:0];
            r_value    <= i_s_tdata[64 +: VALUE_BITS];
        end
        if (resolve) begin
            r_out_status <= n_status;
            r_out_read   <= n_read;
            r_wr_idx     <= n_wr_idx;
            r_wr_key     <= r_key;
            r_wr_value   <= store_value;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_read, r_out_status};

    // entry update lands only once the command has left the chain
    a_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr.en |-> (r_state == kvt_pkg::S_IDLE))
        else $error("entry write outside idle");

    a_tok_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok[ENTRIES].tv |-> (r_state == kvt_pkg::S_SCAN))
        else $error("search token left the chain outside scan");

    a_wr_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_wr.claim && r_wr.clear))
        else $error("claim and clear in the same write");

    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == kvt_pkg::S_RESOLVE))
        else $error("result beat raised without a resolved command");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_start && r_state == kvt_pkg::S_SCAN))
        else $error("accepted command did not launch a search");

endmodule

// ===== sim/tb_key_value_table.sv =====
// Self-checking bench for key_value_table: directed table walk, then random phases.
// Predicts results from a local table copy or the row; depends on kvt_pkg and the RTL.
module tb_key_value_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ENTRIES = kvt_pkg::ENTRIES_DEF;
    localparam int POOL_SIZE = 32;
    localparam int PHASE_ITEMS = 280;

    typedef struct {
        kvt_pkg::t_status status;
        logic [63:0]      read_value;
    } t_kv_result;

    typedef struct {
        kvt_pkg::t_action act;
        logic [31:0]      key;
        logic [31:0]      src_key;
        logic [63:0]      value;
        int               reps;      // key and value step by one per repeat
        bit               typed;     // expectation given in the row itself
        kvt_pkg::t_status exp_status;
        logic [63:0]      exp_value;
    } t_kv_row;

    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [127:0] i_s_tdata  = '0;   // key[31:0], source_key[63:32], value[127:64]
    logic [1:0]   i_s_tuser  = '0;   // action[1:0]
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [71:0]  o_m_tdata;         // status[1:0], read_value[65:2], pad[71:66]

    key_value_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #6 i_clk = ~i_clk;

    // local copy of the table
    bit          tbl_valid [N_ENTRIES];
    logic [31:0] tbl_key   [N_ENTRIES];
    logic [63:0] tbl_value [N_ENTRIES];

    t_kv_result  pending_results [$];
    int          error_count  = 0;
    int          results_seen = 0;
    int          burst_left   = 0;
    logic [31:0] key_pool [POOL_SIZE];

    t_kv_row directed_rows [23] = '{
        '{kvt_pkg::ACT_GET,   32'h0000_0000, 32'h0,         64'h0, 1, 1'b1,
          kvt_pkg::ST_NOT_FOUND, 64'h0},
        '{kvt_pkg::ACT_CLEAR, 32'h7fff_ffff, 32'h0,         64'h0, 1, 1'b1,
          kvt_pkg::ST_NOT_FOUND, 64'h0},
        '{kvt_pkg::ACT_COPY,  32'h0000_0006, 32'h0000_0005, 64'h0, 1, 1'b1,
          kvt_pkg::ST_NOT_FOUND, 64'h0},
        '{kvt_pkg::ACT_SET,   32'h8000_0000, 32'h0, 64'hffff_ffff_ffff_ffff, 1, 1'b1,
          kvt_pkg::ST_DONE, 64'h0},
        '{kvt_pkg::ACT_GET,   32'h8000_0000, 32'h0, 64'h0, 1, 1'b1,
          kvt_pkg::ST_DONE, 64'hffff_ffff_ffff_ffff},
        '{kvt_pkg::ACT_SET,   32'h7fff_ffff, 32'h0,         64'h0, 1, 1'b1,
          kvt_pkg::ST_DONE, 64'h0},
        '{kvt_pkg::ACT_GET,   32'h7fff_ffff, 32'h0,         64'h0, 1, 1'b1,
          kvt_pkg::ST_DONE, 64'h0},
        '{kvt_pkg::ACT_SET,   32'h8000_0000, 32'h0, 64'h8000_0000_0000_0001, 1, 1'b0,
          kvt_pkg::ST_DONE, 64'h0},
        '{kvt_pkg::ACT_COPY,  32'h7fff_ffff, 32'h8000_0000, 64'h0, 1, 1'b0,
          kvt_pkg::ST_DONE, 64'h0},
        '{kvt_pkg::ACT_GET,   32'h7fff_ffff, 32'h0,         64'h0, 1, 1'b0,
          kvt_pkg::ST_DONE, 64'h0},
        // copy onto itself keeps the value
        '{kvt_pkg::ACT_COPY,  32'h7fff_ffff, 32'h7fff_ffff, 64'h0, 1, 1'b1,
          kvt_pkg::ST_DONE, 64'h0},
        '{kvt_pkg::ACT_GET,   32'h7fff_ffff, 32'h0,         64'h0, 1, 1'b0,
          kvt_pkg::ST_DONE, 64'h0},
        '{kvt_pkg::ACT_CLEAR, 32'h8000_0000, 32'h0,         64'h0, 1, 1'b1,
          kvt_pkg::ST_DONE, 64'h0},
        '{kvt_pkg::ACT_GET,   32'h8000_0000, 32'h0,         64'h0, 1, 1'b1,
          kvt_pkg::ST_NOT_FOUND, 64'h0},
        // fill every free entry
        '{kvt_pkg::ACT_SET,   32'h0000_0100, 32'h0, 64'h0123_4567_89ab_cdef, 15, 1'b0,
          kvt_pkg::ST_DONE, 64'h0},
        '{kvt_pkg::ACT_SET,   32'h0000_0055, 32'h0,         64'h0, 1, 1'b1,
          kvt_pkg::ST_FULL, 64'h0},
        '{kvt_pkg::ACT_COPY,  32'h0000_0056, 32'h7fff_ffff, 64'h0, 1, 1'b1,
          kvt_pkg::ST_FULL, 64'h0},
        // missing source wins over a full table
        '{kvt_pkg::ACT_COPY,  32'h0000_0057, 32'h0000_0999, 64'h0, 1, 1'b1,
          kvt_pkg::ST_NOT_FOUND, 64'h0},
        '{kvt_pkg::ACT_SET,   32'h0000_0105, 32'h0, 64'h5a5a_5a5a_5a5a_5a5a, 1, 1'b0,
          kvt_pkg::ST_DONE, 64'h0},
        '{kvt_pkg::ACT_CLEAR, 32'h0000_0100, 32'h0,         64'h0, 1, 1'b1,
          kvt_pkg::ST_DONE, 64'h0},
        '{kvt_pkg::ACT_SET,   32'h0000_0055, 32'h0, 64'haaaa_aaaa_aaaa_aaaa, 1, 1'b0,
          kvt_pkg::ST_DONE, 64'h0},
        '{kvt_pkg::ACT_GET,   32'h0000_0055, 32'h0,         64'h0, 1, 1'b0,
          kvt_pkg::ST_DONE, 64'h0},
        '{kvt_pkg::ACT_CLEAR, 32'h0000_0100, 32'h0,         64'h0, 16, 1'b0,
          kvt_pkg::ST_DONE, 64'h0}
    };

    function automatic int lookup_entry(logic [31:0] k);
        for (int i = 0; i < N_ENTRIES; i++)
            if (tbl_valid[i] && tbl_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic int first_free_entry();
        for (int i = 0; i < N_ENTRIES; i++)
            if (!tbl_valid[i])
                return i;
        return -1;
    endfunction

    function automatic kvt_pkg::t_status write_entry(logic [31:0] k, logic [63:0] v);
        int s;
        s = lookup_entry(k);
        if (s < 0) begin
            s = first_free_entry();
            if (s < 0)
                return kvt_pkg::ST_FULL;
            tbl_key[s]   = k;
            tbl_valid[s] = 1'b1;
        end
        tbl_value[s] = v;
        return kvt_pkg::ST_DONE;
    endfunction

    function automatic t_kv_result predict_command(kvt_pkg::t_action act, logic [31:0] k,
                                                   logic [31:0] src, logic [63:0] v);
        t_kv_result r;
        int s;
        r = '{kvt_pkg::ST_DONE, 64'h0};
        case (act)
            kvt_pkg::ACT_SET: begin
                r.status = write_entry(k, v);
            end
            kvt_pkg::ACT_GET: begin
                s = lookup_entry(k);
                if (s < 0)
                    r.status = kvt_pkg::ST_NOT_FOUND;
                else
                    r.read_value = tbl_value[s];
            end
            kvt_pkg::ACT_COPY: begin
                s = lookup_entry(src);
                if (s < 0)
                    r.status = kvt_pkg::ST_NOT_FOUND;
                else
                    r.status = write_entry(k, tbl_value[s]);
            end
            default: begin
                s = lookup_entry(k);
                if (s < 0)
                    r.status = kvt_pkg::ST_NOT_FOUND;
                else
                    tbl_valid[s] = 1'b0;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch: %s at result %0d, got %h, expected %h", what, results_seen, got, want);
        error_count++;
    endtask

    // sender: bursts of random length, gaps of random length between them
    task automatic take_gap();
        int gap;
        if (burst_left > 0)
            return;
        case ($urandom_range(3))
            0:       gap = 0;
            1:       gap = $urandom_range(1, 3);
            2:       gap = $urandom_range(4, 12);
            default: gap = $urandom_range(13, 30);
        endcase
        burst_left = $urandom_range(1, 20);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_command(kvt_pkg::t_action act, logic [31:0] k, logic [31:0] src,
                                logic [63:0] v, bit typed, kvt_pkg::t_status es,
                                logic [63:0] ev);
        t_kv_result r;
        take_gap();
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {v, src, k};
        do @(posedge i_clk); while (!o_s_tready);
        r = predict_command(act, k, src, v);
        if (typed)
            r = '{es, ev};
        pending_results.push_back(r);
        burst_left--;
    endtask

    // stop offering until every result is back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        burst_left = 0;
    endtask

    function automatic logic [31:0] pick_key(int n);
        if ($urandom_range(9) == 0)
            return $urandom;
        return key_pool[$urandom_range(n - 1)];
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(15))
            0:       return 64'h0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic kvt_pkg::t_action pick_action(int w_set, int w_get, int w_copy,
                                                     int w_clear);
        int r;
        r = $urandom_range(w_set + w_get + w_copy + w_clear - 1);
        if (r < w_set)
            return kvt_pkg::ACT_SET;
        if (r < w_set + w_get)
            return kvt_pkg::ACT_GET;
        if (r < w_set + w_get + w_copy)
            return kvt_pkg::ACT_COPY;
        return kvt_pkg::ACT_CLEAR;
    endfunction

    // stimulus
    initial begin : stimulus
        int               phase_keys [5] = '{6, 32, 24, 32, 10};
        int               w_set      [5] = '{3, 6, 2, 1, 3};
        int               w_get      [5] = '{3, 2, 2, 2, 3};
        int               w_copy     [5] = '{2, 1, 5, 1, 2};
        int               w_clear    [5] = '{2, 1, 1, 6, 2};
        kvt_pkg::t_action act;
        logic [31:0]      k;
        logic [31:0]      src;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            for (int j = 0; j < directed_rows[r].reps; j++)
                send_command(directed_rows[r].act, directed_rows[r].key + j,
                             directed_rows[r].src_key, directed_rows[r].value + j,
                             directed_rows[r].typed, directed_rows[r].exp_status,
                             directed_rows[r].exp_value);

        foreach (key_pool[i])
            key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;

        // small pools give hits; the wide ones overflow the table
        for (int p = 0; p < 5; p++) begin
            drain_results();
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                act = pick_action(w_set[p], w_get[p], w_copy[p], w_clear[p]);
                k   = pick_key(phase_keys[p]);
                src = (act == kvt_pkg::ACT_COPY && $urandom_range(9) == 0) ?
                      k : pick_key(phase_keys[p]);
                send_command(act, k, src, pick_value(), 1'b0, kvt_pkg::ST_DONE, 64'h0);
            end
        end

        drain_results();
        repeat (N_ENTRIES + 8) @(posedge i_clk);
        if (error_count == 0)
            $display("PASS key_value_table");
        else
            $display("FAIL key_value_table");
        $finish;
    end

    // receiver: changing stall pattern, plus one long hold-off
    initial begin : receiver
        int mode      = 0;
        int mode_left = 0;
        int hold_left = 0;
        bit hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (!hold_done && results_seen >= 250) begin
                hold_left = 240;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                case (mode)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= $urandom_range(1);
                    2:       i_m_tready <= (mode_left % 4 == 0);
                    default: i_m_tready <= ($urandom_range(9) > 2);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_kv_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", o_m_tdata[65:2], 64'h0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[1:0] != want.status)
                    report_mismatch("status", 64'(o_m_tdata[1:0]), 64'(want.status));
                if (o_m_tdata[65:2] != want.read_value)
                    report_mismatch("read_value", o_m_tdata[65:2], want.read_value);
            end
            results_seen++;
        end
    end

    initial begin : watchdog
        #10ms;
        $display("FAIL key_value_table");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/kvt_pkg.sv
hdl/kvt_cell.sv
hdl/key_value_table.sv
sim/tb_key_value_table.sv
